>>> rtl/core/ufcc_pkg.sv
// ----------------------------------------------------------------------------
// ufcc_pkg
// Types and constants shared by the union-find component counter modules.
// ----------------------------------------------------------------------------
package ufcc_pkg;

    localparam int CmdWidth   = 1;
    localparam int NodeWidth  = 5;
    localparam int CountWidth = 6;

    localparam logic [CmdWidth-1:0] CMD_CLEAR = 1'b0;
    localparam logic [CmdWidth-1:0] CMD_UNION = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_WALK_REQ,
        S_WALK_CHK,
        S_COMP_REQ,
        S_COMP_WR,
        S_LINK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic clr_wr;
        logic rd;
        logic walk_next;
        logic set_root;
        logic sel_b;
        logic start_b;
        logic comp_wr;
        logic link;
        logic out_load;
    } t_ufcc_cmd;

    typedef struct packed {
        logic item_clear;
        logic item_invalid;
        logic sweep_last;
        logic rd_is_cur;
        logic cur_is_root;
    } t_ufcc_sts;

endpackage

>>> rtl/core/ufcc_if.sv
// ----------------------------------------------------------------------------
// ufcc_in_if / ufcc_out_if
// Valid-ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface ufcc_in_if;
    import ufcc_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CmdWidth-1:0]  cmd;
    logic [NodeWidth-1:0] node_a;
    logic [NodeWidth-1:0] node_b;

    modport source (output valid, output cmd, output node_a, output node_b, input ready);
    modport sink   (input valid, input cmd, input node_a, input node_b, output ready);
endinterface

interface ufcc_out_if;
    import ufcc_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CountWidth-1:0] component_count;
    logic                  merged;
    logic                  invalid;

    modport source (output valid, output component_count, output merged, output invalid,
                    input ready);
    modport sink   (input valid, input component_count, input merged, input invalid,
                    output ready);
endinterface

>>> rtl/core/ufcc_ctrl.sv
// ----------------------------------------------------------------------------
// ufcc_ctrl
// Sequencer for clear sweeps, root walks, path compression and linking.
// ----------------------------------------------------------------------------
module ufcc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  ufcc_pkg::t_ufcc_sts i_sts,
    output ufcc_pkg::t_ufcc_cmd o_cmd
);
    import ufcc_pkg::*;

    t_state r_state, n_state;
    logic   r_boot, n_boot;
    logic   r_phase, n_phase;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_boot      <= 1'b1;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_boot      <= n_boot;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_boot      = r_boot;
        n_phase     = r_phase;
        n_out_valid = r_out_valid & ~i_out_ready;
        o_cmd       = '0;
        o_cmd.sel_b = r_phase;
        o_in_ready  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_phase    = 1'b0;
                    if (i_sts.item_clear) begin
                        n_state = S_CLEAR;
                    end else if (i_sts.item_invalid) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_WALK_REQ;
                    end
                end
            end
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.sweep_last) begin
                    n_boot  = 1'b0;
                    n_state = r_boot ? S_IDLE : S_DONE;
                end
            end
            S_WALK_REQ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_WALK_CHK;
            end
            S_WALK_CHK: begin
                if (i_sts.rd_is_cur) begin
                    o_cmd.set_root = 1'b1;
                    n_state        = S_COMP_REQ;
                end else begin
                    o_cmd.walk_next = 1'b1;
                    n_state         = S_WALK_REQ;
                end
            end
            S_COMP_REQ: begin
                if (i_sts.cur_is_root) begin
                    if (!r_phase) begin
                        o_cmd.start_b = 1'b1;
                        n_phase       = 1'b1;
                        n_state       = S_WALK_REQ;
                    end else begin
                        n_state = S_LINK;
                    end
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_COMP_WR;
                end
            end
            S_COMP_WR: begin
                o_cmd.comp_wr = 1'b1;
                n_state       = S_COMP_REQ;
            end
            S_LINK: begin
                o_cmd.link = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/core/ufcc_datapath.sv
// ----------------------------------------------------------------------------
// ufcc_datapath
// Parent memory, walk registers, component count and result register.
// ----------------------------------------------------------------------------
module ufcc_datapath #(
    parameter int NODES = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ufcc_pkg::CountWidth-1:0]    i_cfg_data,
    input  logic [ufcc_pkg::CmdWidth-1:0]      i_cmd,
    input  logic [ufcc_pkg::NodeWidth-1:0]     i_node_a,
    input  logic [ufcc_pkg::NodeWidth-1:0]     i_node_b,
    input  ufcc_pkg::t_ufcc_cmd                i_ctl,
    output ufcc_pkg::t_ufcc_sts                o_sts,
    output logic [ufcc_pkg::CountWidth-1:0]    o_component_count,
    output logic                               o_merged,
    output logic                               o_invalid
);
    import ufcc_pkg::*;

    localparam int IW         = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int LimMax     = (NODES < 63) ? NODES : 63;
    localparam int CountReset = (NODES < 32) ? NODES : 32;

    logic [IW-1:0]         r_mem [NODES];
    logic [IW-1:0]         r_rd_data;
    logic [IW-1:0]         r_sweep;
    logic [IW-1:0]         r_cur;
    logic [IW-1:0]         r_root;
    logic [IW-1:0]         r_x;
    logic [IW-1:0]         r_b;
    logic [IW-1:0]         r_a;
    logic [CountWidth-1:0] r_node_count;
    logic [CountWidth-1:0] r_count;
    logic                  r_merged;
    logic                  r_invalid;
    logic [CountWidth-1:0] r_out_count;
    logic                  r_out_merged;
    logic                  r_out_invalid;

    logic [CountWidth-1:0] lim;
    logic                  roots_differ;
    logic                  mem_we;
    logic [IW-1:0]         mem_wa;
    logic [IW-1:0]         mem_wd;

    assign lim = (r_node_count < CountWidth'(LimMax)) ? r_node_count : CountWidth'(LimMax);
    assign roots_differ = (r_x != r_root);

    assign o_sts.item_clear   = (i_cmd == CMD_CLEAR);
    assign o_sts.item_invalid = (i_cmd == CMD_UNION) &&
                                (({1'b0, i_node_a} >= lim) || ({1'b0, i_node_b} >= lim));
    assign o_sts.sweep_last   = (r_sweep == IW'(NODES - 1));
    assign o_sts.rd_is_cur    = (r_rd_data == r_cur);
    assign o_sts.cur_is_root  = (r_cur == r_root);

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_cur;
        mem_wd = r_root;
        if (i_ctl.clr_wr) begin
            mem_we = 1'b1;
            mem_wa = r_sweep;
            mem_wd = r_sweep;
        end else if (i_ctl.comp_wr) begin
            mem_we = 1'b1;
        end else if (i_ctl.link && roots_differ) begin
            mem_we = 1'b1;
            mem_wa = r_x;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (i_ctl.rd) begin
            r_rd_data <= r_mem[r_cur];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= CountWidth'(32);
            r_count      <= CountWidth'(CountReset);
            r_sweep      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_node_count <= i_cfg_data;
            end
            if (i_ctl.load) begin
                r_sweep <= '0;
                if (i_cmd == CMD_CLEAR) begin
                    r_count <= lim;
                end
            end else if (i_ctl.clr_wr) begin
                r_sweep <= o_sts.sweep_last ? '0 : r_sweep + 1'b1;
            end
            if (i_ctl.link && roots_differ && (r_count != '0)) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_a       <= IW'(i_node_a);
            r_b       <= IW'(i_node_b);
            r_cur     <= IW'(i_node_a);
            r_merged  <= 1'b0;
            r_invalid <= o_sts.item_invalid;
        end
        if (i_ctl.walk_next) begin
            r_cur <= r_rd_data;
        end
        if (i_ctl.set_root) begin
            r_root <= r_cur;
            r_cur  <= i_ctl.sel_b ? r_b : r_a;
        end
        if (i_ctl.comp_wr) begin
            r_cur <= r_rd_data;
        end
        if (i_ctl.start_b) begin
            r_x   <= r_root;
            r_cur <= r_b;
        end
        if (i_ctl.link && roots_differ) begin
            r_merged <= 1'b1;
        end
        if (i_ctl.out_load) begin
            r_out_count   <= r_count;
            r_out_merged  <= r_merged;
            r_out_invalid <= r_invalid;
        end
    end

    assign o_component_count = r_out_count;
    assign o_merged          = r_out_merged;
    assign o_invalid         = r_out_invalid;

endmodule

>>> rtl/core/union_find_component_counter.sv
// ----------------------------------------------------------------------------
// union_find_component_counter
// Disjoint-set engine that counts connected components with path compression.
// ----------------------------------------------------------------------------
// Command words arrive on i_item: a clear word resets every set and loads the
// count from node_count, capped at NODES and 63; a union word joins the sets
// of node_a and node_b. Each command word yields one result word on o_result
// carrying the component count and the merged and invalid flags. The user must
// write node_count through i_cfg_we and i_cfg_data only while the block is idle;
// the block itself does not enforce this. A clear writes one parent entry per
// cycle. An invalid union skips the root walks. A valid union walks to the root
// of node_a and compresses that path, does the same for node_b, then links the
// two roots. One word is worked on at a time. After reset the parent memory is
// swept with i_item not ready. The result sits in an output register, so the
// next command word is accepted while a result is still waiting; a finished
// word waits only when that register is still full.
// ----------------------------------------------------------------------------
module union_find_component_counter #(
    parameter int NODES = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ufcc_pkg::CountWidth-1:0] i_cfg_data,
    ufcc_in_if.sink                         i_item,
    ufcc_out_if.source                      o_result
);
    import ufcc_pkg::*;

    t_ufcc_cmd ctl;
    t_ufcc_sts sts;

    ufcc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (i_item.ready),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .i_sts       (sts),
        .o_cmd       (ctl)
    );

    ufcc_datapath #(
        .NODES (NODES)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_cmd             (i_item.cmd),
        .i_node_a          (i_item.node_a),
        .i_node_b          (i_item.node_b),
        .i_ctl             (ctl),
        .o_sts             (sts),
        .o_component_count (o_result.component_count),
        .o_merged          (o_result.merged),
        .o_invalid         (o_result.invalid)
    );

endmodule
